>>> src/fumrf_pkg.sv
// shared types and constants for the fasta unmasked run finder
// no dependencies; imported by fasta_unmasked_run_finder_unit
package fumrf_pkg;

	// width of the position counters inside the scanner
	localparam int POS_WIDTH = 32;

	// output queue depth, must be a power of two and at least two
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [15:0] MIN_RUN_RESET = 16'd100;
	localparam logic [7:0]  X_INDEX_RESET = 8'd22;

	// register indexes, taken from paddr[2]
	localparam logic REG_MIN_RUN = 1'b0;
	localparam logic REG_X_INDEX = 1'b1;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_RECORD  = 1'b1;

	typedef struct packed {
		logic              item_kind;
		logic signed [8:0] chrom_index;
		logic [31:0]       seg_start;
		logic [31:0]       seg_end;
		logic [31:0]       seq_length;
		logic              last;
	} result_t;

endpackage

>>> src/fasta_unmasked_run_finder_unit.sv
// fasta unmasked run finder: byte-serial header parser and non-N run tracker
// depends on fumrf_pkg for the result type, register indexes and reset values
//
// a byte is registered at acceptance, and its results enter the output queue from
// that register once the queue has room for two; out_valid flags a non-empty queue.
// throughput: one byte per cycle; a byte that makes two results fills two queue
// entries, and input stalls once the four-entry output queue cannot take two more.
// reset: arst_n clears the parse state, the queue and the registers at once.
module fasta_unmasked_run_finder_unit
	import fumrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// byte input
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        text_byte,
	input  logic              last_byte,
	// result output
	output logic              out_valid,
	input  logic              out_ready,
	output logic              item_kind,
	output logic signed [8:0] chrom_index,
	output logic [31:0]       seg_start,
	output logic [31:0]       seg_end,
	output logic [31:0]       seq_length,
	output logic              last,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		MODE_SEEK,
		MODE_HEADER,
		MODE_SEQ,
		MODE_SKIP
	} mode_t;

	localparam logic [2:0] PROG_AFTER_PREFIX = 3'd4;
	localparam logic [2:0] PROG_AFTER_X      = 3'd5;
	localparam logic [2:0] PROG_IN_DIGITS    = 3'd6;
	localparam logic [2:0] PROG_DIGITS_DONE  = 3'd7;

	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_C       = 8'h63;
	localparam logic [7:0] CH_H       = 8'h68;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_X       = 8'h58;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = CH_GT;
			2'd1:    ch = CH_C;
			2'd2:    ch = CH_H;
			default: ch = CH_R;
		endcase
		return ch;
	endfunction

	// configuration
	logic [15:0] min_run_q;
	logic [7:0]  x_index_q;
	logic        cfg_wr;

	// input stage
	logic        vld_s1;
	logic [7:0]  text_s1;
	logic        last_s1;
	logic        adv;

	// parse state
	mode_t                mode_q, mode_d;
	logic [2:0]           prog_q, prog_d;
	logic                 und_q, und_d;
	logic                 dig_q, dig_d;
	logic                 xcand_q, xcand_d;
	logic                 fail_q, fail_d;
	logic [7:0]           num_q, num_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;
	logic                 in_run_q, in_run_d;
	logic [POS_WIDTH-1:0] run_start_q, run_start_d;

	// output queue
	result_t        q_mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           pop;
	logic [1:0]     n_res;
	result_t        res0, res1;

	// byte decode helpers
	logic                 is_digit;
	logic [3:0]           digit_val;
	logic [11:0]          num_mac;
	logic [POS_WIDTH-1:0] run_len;
	logic                 long_run;
	logic signed [8:0]    cur_index;
	logic                 hdr_ok;
	result_t              seg_res;
	result_t              rec_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_MIN_RUN: prdata = {16'd0, min_run_q};
			REG_X_INDEX: prdata = {24'd0, x_index_q};
			default:     prdata = '0;
		endcase
	end

	assign pop       = out_valid && out_ready;
	// stage advances only if the queue has room for two results
	assign adv       = vld_s1 && (count_q <= (QAW+1)'(QDEPTH - 2));
	assign in_ready  = !vld_s1 || adv;
	assign out_valid = (count_q != '0);

	assign item_kind   = q_mem[rd_ptr_q].item_kind;
	assign chrom_index = q_mem[rd_ptr_q].chrom_index;
	assign seg_start   = q_mem[rd_ptr_q].seg_start;
	assign seg_end     = q_mem[rd_ptr_q].seg_end;
	assign seq_length  = q_mem[rd_ptr_q].seq_length;
	assign last        = q_mem[rd_ptr_q].last;

	assign is_digit  = (text_s1 >= CH_ZERO) && (text_s1 <= CH_NINE);
	assign digit_val = 4'(text_s1 - CH_ZERO);
	assign num_mac   = 12'({num_q, 3'b000}) + 12'({num_q, 1'b0}) + 12'(digit_val);
	assign run_len   = pos_q - run_start_q;
	assign long_run  = run_len > POS_WIDTH'(min_run_q);
	assign cur_index = xcand_q ? $signed({1'b0, x_index_q})
	                           : $signed({1'b0, num_q} - 9'd1);
	assign hdr_ok    = !(und_q || fail_q) && (dig_q || xcand_q);

	always_comb begin
		seg_res.item_kind   = KIND_SEGMENT;
		seg_res.chrom_index = cur_index;
		seg_res.seg_start   = 32'(run_start_q);
		seg_res.seg_end     = 32'(pos_q);
		seg_res.seq_length  = '0;
		seg_res.last        = 1'b0;
		rec_res.item_kind   = KIND_RECORD;
		rec_res.chrom_index = cur_index;
		rec_res.seg_start   = '0;
		rec_res.seg_end     = '0;
		rec_res.seq_length  = 32'(pos_q);
		rec_res.last        = 1'b1;
	end

	always_comb begin
		mode_d      = mode_q;
		prog_d      = prog_q;
		und_d       = und_q;
		dig_d       = dig_q;
		xcand_d     = xcand_q;
		fail_d      = fail_q;
		num_d       = num_q;
		pos_d       = pos_q;
		in_run_d    = in_run_q;
		run_start_d = run_start_q;
		n_res       = 2'd0;
		res0        = seg_res;
		res1        = rec_res;
		if (adv) begin
			case (mode_q)
				MODE_SEEK: begin
					if (text_s1 == CH_GT) begin
						mode_d  = MODE_HEADER;
						prog_d  = 3'd1;
						und_d   = 1'b0;
						dig_d   = 1'b0;
						xcand_d = 1'b0;
						fail_d  = 1'b0;
						num_d   = '0;
					end
				end
				MODE_HEADER: begin
					if (text_s1 == CH_NL) begin
						mode_d      = hdr_ok ? MODE_SEQ : MODE_SKIP;
						pos_d       = '0;
						in_run_d    = 1'b0;
						run_start_d = '0;
					end else begin
						if (text_s1 == CH_USCORE)
							und_d = 1'b1;
						if (!prog_q[2]) begin
							if (text_s1 == prefix_char(prog_q[1:0])) begin
								prog_d = prog_q + 3'd1;
							end else begin
								fail_d = 1'b1;
								prog_d = PROG_DIGITS_DONE;
							end
						end else if (prog_q == PROG_AFTER_PREFIX) begin
							if (is_digit) begin
								dig_d  = 1'b1;
								num_d  = {4'd0, digit_val};
								prog_d = PROG_IN_DIGITS;
							end else if (text_s1 == CH_X) begin
								xcand_d = 1'b1;
								prog_d  = PROG_AFTER_X;
							end else begin
								fail_d = 1'b1;
								prog_d = PROG_DIGITS_DONE;
							end
						end else if (prog_q == PROG_AFTER_X) begin
							// anything after the X spoils the exact match
							xcand_d = 1'b0;
							prog_d  = PROG_DIGITS_DONE;
						end else if (prog_q == PROG_IN_DIGITS) begin
							if (is_digit) begin
								num_d = (num_mac > 12'd255) ? 8'd255 : num_mac[7:0];
							end else begin
								prog_d = PROG_DIGITS_DONE;
							end
						end
					end
				end
				MODE_SEQ: begin
					if (text_s1 == CH_NL) begin
						if (in_run_q && long_run) begin
							n_res = 2'd2;
						end else begin
							n_res = 2'd1;
							res0  = rec_res;
						end
						in_run_d = 1'b0;
						mode_d   = MODE_HEADER;
						prog_d   = '0;
						und_d    = 1'b0;
						dig_d    = 1'b0;
						xcand_d  = 1'b0;
						fail_d   = 1'b0;
						num_d    = '0;
					end else begin
						if (text_s1 != CH_N) begin
							if (!in_run_q) begin
								in_run_d    = 1'b1;
								run_start_d = pos_q;
							end
						end else if (in_run_q) begin
							in_run_d = 1'b0;
							if (long_run) begin
								n_res     = 2'd1;
								res0.last = 1'b1;
							end
						end
						if (pos_q != '1)
							pos_d = pos_q + POS_WIDTH'(1);
					end
				end
				MODE_SKIP: begin
					if (text_s1 == CH_NL) begin
						mode_d  = MODE_HEADER;
						prog_d  = '0;
						und_d   = 1'b0;
						dig_d   = 1'b0;
						xcand_d = 1'b0;
						fail_d  = 1'b0;
						num_d   = '0;
					end
				end
				default: mode_d = MODE_SEEK;
			endcase
			// end of file drops everything back to seeking
			if (last_s1) begin
				mode_d      = MODE_SEEK;
				prog_d      = '0;
				und_d       = 1'b0;
				dig_d       = 1'b0;
				xcand_d     = 1'b0;
				fail_d      = 1'b0;
				num_d       = '0;
				pos_d       = '0;
				in_run_d    = 1'b0;
				run_start_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q   <= MIN_RUN_RESET;
			x_index_q   <= X_INDEX_RESET;
			vld_s1      <= 1'b0;
			mode_q      <= MODE_SEEK;
			prog_q      <= '0;
			und_q       <= 1'b0;
			dig_q       <= 1'b0;
			xcand_q     <= 1'b0;
			fail_q      <= 1'b0;
			num_q       <= '0;
			pos_q       <= '0;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_MIN_RUN: min_run_q <= pwdata[15:0];
					REG_X_INDEX: x_index_q <= pwdata[7:0];
					default: ;
				endcase
			end
			if (in_ready)
				vld_s1 <= in_valid;
			mode_q      <= mode_d;
			prog_q      <= prog_d;
			und_q       <= und_d;
			dig_q       <= dig_d;
			xcand_q     <= xcand_d;
			fail_q      <= fail_d;
			num_q       <= num_d;
			pos_q       <= pos_d;
			in_run_q    <= in_run_d;
			run_start_q <= run_start_d;
			wr_ptr_q    <= wr_ptr_q + QAW'(n_res);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			count_q <= count_q + (QAW+1)'(n_res) - (QAW+1)'(pop);
		end
	end

	// input byte register and queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready) begin
			text_s1 <= text_byte;
			last_s1 <= last_byte;
		end
		if (n_res != 2'd0)
			q_mem[wr_ptr_q] <= res0;
		if (n_res == 2'd2)
			q_mem[wr_ptr_q + QAW'(1)] <= res1;
	end

endmodule

>>> tb/tb_fasta_unmasked_run_finder_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for fasta_unmasked_run_finder_unit: header parsing, non-N runs, records
// depends on fumrf_pkg and the unit's rtl; a byte-level predictor feeds an in-order result check
module tb_fasta_unmasked_run_finder_unit;
	import fumrf_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES   = 6;

	localparam logic [7:0] CH_GT   = ">";
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_N    = "N";
	localparam logic [7:0] CH_X    = "X";
	localparam logic [7:0] CH_US   = "_";
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";

	// header progress through ">chr", then the part after the prefix
	localparam logic [2:0] HDR_START       = 3'd0;
	localparam logic [2:0] HDR_AFTER_GT    = 3'd1;
	localparam logic [2:0] HDR_AFTER_C     = 3'd2;
	localparam logic [2:0] HDR_AFTER_H     = 3'd3;
	localparam logic [2:0] HDR_PREFIX_DONE = 3'd4;
	localparam logic [2:0] HDR_AFTER_X     = 3'd5;
	localparam logic [2:0] HDR_IN_DIGITS   = 3'd6;
	localparam logic [2:0] HDR_DONE        = 3'd7;

	typedef enum logic [1:0] {SCAN_SEEK, SCAN_HEADER, SCAN_SEQ, SCAN_SKIP} scan_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        text_byte = 8'd0;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              item_kind;
	logic signed [8:0] chrom_index;
	logic [31:0]       seg_start;
	logic [31:0]       seg_end;
	logic [31:0]       seq_length;
	logic              last;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = 3'd0;
	logic [31:0]       pwdata = 32'd0;
	logic [31:0]       prdata;
	logic              pready;

	// predictor state
	scan_mode_t           scan_mode;
	logic [2:0]           hdr_step;
	logic                 hdr_underscore, hdr_digits, hdr_xcand, hdr_fail;
	logic [7:0]           chrom_num;
	logic [POS_WIDTH-1:0] seq_pos, run_start;
	logic                 in_run;
	logic [15:0]          min_run_cfg;
	logic [7:0]           x_index_cfg;
	result_t              unmasked_items_q[$];

	logic [7:0] file_text_q[$];
	int tx_idle_pct, rx_idle_pct;
	int rx_hold_left = 0;
	int errors = 0;
	int bytes_sent = 0;
	int parsed_bytes = 0;
	int results_seen = 0;
	int cycle_count = 0;

	fasta_unmasked_run_finder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready), .item_kind(item_kind),
		.chrom_index(chrom_index), .seg_start(seg_start), .seg_end(seg_end),
		.seq_length(seq_length), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending", $time,
				cycle_count, unmasked_items_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready = 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else
			out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
	end

	function automatic void reset_scan();
		scan_mode = SCAN_SEEK;
		hdr_step = HDR_START;
		{hdr_underscore, hdr_digits, hdr_xcand, hdr_fail} = 4'b0;
		chrom_num = 8'd0;
		seq_pos = '0;
		in_run = 1'b0;
		run_start = '0;
	endfunction

	function automatic void open_header(input logic [2:0] step);
		scan_mode = SCAN_HEADER;
		hdr_step = step;
		{hdr_underscore, hdr_digits, hdr_xcand, hdr_fail} = 4'b0;
		chrom_num = 8'd0;
	endfunction

	function automatic void queue_item(input logic kind, input logic [POS_WIDTH-1:0] s, e, len,
		input logic lst);
		result_t r;
		r.item_kind = kind;
		r.chrom_index = hdr_xcand ? {1'b0, x_index_cfg} : {1'b0, chrom_num} - 9'd1;
		r.seg_start = s[31:0];
		r.seg_end = e[31:0];
		r.seq_length = len[31:0];
		r.last = lst;
		unmasked_items_q.push_back(r);
	endfunction

	function automatic void track_text_byte(input logic [7:0] b, input logic eof);
		logic                 is_digit;
		logic [7:0]           want;
		logic [POS_WIDTH-1:0] run_len;
		int                   acc;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		run_len = seq_pos - run_start;
		if (scan_mode == SCAN_HEADER || scan_mode == SCAN_SEQ)
			parsed_bytes++;
		case (scan_mode)
			SCAN_SEEK: begin
				if (b == CH_GT)
					open_header(HDR_AFTER_GT);
			end
			SCAN_HEADER: begin
				if (b == CH_LF) begin
					scan_mode = (!hdr_underscore && !hdr_fail && (hdr_digits || hdr_xcand)) ?
						SCAN_SEQ : SCAN_SKIP;
					seq_pos = '0;
					in_run = 1'b0;
					run_start = '0;
				end else begin
					if (b == CH_US)
						hdr_underscore = 1'b1;
					if (hdr_step < HDR_PREFIX_DONE) begin
						case (hdr_step)
							HDR_AFTER_GT: want = "c";
							HDR_AFTER_C:  want = "h";
							HDR_AFTER_H:  want = "r";
							default:      want = CH_GT;
						endcase
						if (b == want)
							hdr_step = hdr_step + 3'd1;
						else begin
							hdr_fail = 1'b1;
							hdr_step = HDR_DONE;
						end
					end else if (hdr_step == HDR_PREFIX_DONE) begin
						if (is_digit) begin
							hdr_digits = 1'b1;
							chrom_num = b - CH_ZERO;
							hdr_step = HDR_IN_DIGITS;
						end else if (b == CH_X) begin
							hdr_xcand = 1'b1;
							hdr_step = HDR_AFTER_X;
						end else begin
							hdr_fail = 1'b1;
							hdr_step = HDR_DONE;
						end
					end else if (hdr_step == HDR_AFTER_X) begin
						// anything after the X spoils the exact match
						hdr_xcand = 1'b0;
						hdr_step = HDR_DONE;
					end else if (hdr_step == HDR_IN_DIGITS) begin
						if (is_digit) begin
							acc = chrom_num * 10 + int'(b - CH_ZERO);
							chrom_num = (acc > 255) ? 8'd255 : acc[7:0];
						end else
							hdr_step = HDR_DONE;
					end
				end
			end
			SCAN_SEQ: begin
				if (b == CH_LF) begin
					if (in_run && run_len > min_run_cfg)
						queue_item(KIND_SEGMENT, run_start, seq_pos, '0, 1'b0);
					queue_item(KIND_RECORD, '0, '0, seq_pos, 1'b1);
					in_run = 1'b0;
					open_header(HDR_START);
				end else begin
					if (b != CH_N) begin
						if (!in_run) begin
							in_run = 1'b1;
							run_start = seq_pos;
						end
					end else if (in_run) begin
						in_run = 1'b0;
						if (run_len > min_run_cfg)
							queue_item(KIND_SEGMENT, run_start, seq_pos, '0, 1'b1);
					end
					if (seq_pos != '1)
						seq_pos = seq_pos + 1'b1;
				end
			end
			default: begin
				if (b == CH_LF)
					open_header(HDR_START);
			end
		endcase
		if (eof)
			reset_scan();
	endfunction

	task automatic check_field(input string field, input logic signed [63:0] want, got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (unmasked_items_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, kind %0d index %0d start %0d end %0d len %0d",
					$time, item_kind, chrom_index, seg_start, seg_end, seq_length);
			end else begin
				want = unmasked_items_q.pop_front();
				check_field("item_kind", want.item_kind, item_kind);
				check_field("chrom_index", want.chrom_index, chrom_index);
				check_field("seg_start", want.seg_start, seg_start);
				check_field("seg_end", want.seg_end, seg_end);
				check_field("seq_length", want.seq_length, seq_length);
				check_field("last", want.last, last);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eof);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		text_byte = b;
		last_byte = eof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_text_byte(b, eof);
		bytes_sent++;
	endtask

	task automatic send_file_text(input bit eof_last);
		int n;
		n = file_text_q.size();
		for (int i = 0; i < n; i++)
			push_byte(file_text_q[i], eof_last && (i == n - 1));
		file_text_q.delete();
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			file_text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] any_byte_but(input logic [7:0] a, c);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == c);
		return v;
	endfunction

	function automatic void add_digits();
		repeat ($urandom_range(1, 4))
			file_text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic logic [7:0] seq_char();
		string bases;
		bases = "ACGTacgtn";
		if ($urandom_range(0, 9) == 0)
			return any_byte_but(CH_LF, CH_N);
		return bases[$urandom_range(0, 8)];
	endfunction

	// at a threshold of 40 or less, runs may cluster around it so that both sides of it are hit
	function automatic void add_sequence_line();
		int mr, len;
		mr = int'(min_run_cfg);
		repeat ($urandom_range(0, 5)) begin
			if (mr <= 40 && $urandom_range(0, 1))
				len = $urandom_range((mr == 0) ? 0 : mr - 1, mr + 2);
			else
				len = $urandom_range(0, 6);
			repeat (len)
				file_text_q.push_back(seq_char());
			repeat ($urandom_range(1, 3))
				file_text_q.push_back(CH_N);
		end
		if ($urandom_range(0, 1))
			repeat ($urandom_range(0, (mr <= 40) ? mr + 2 : 6))
				file_text_q.push_back(seq_char());
		file_text_q.push_back(CH_LF);
	endfunction

	task automatic send_random_genome();
		int kind, cut;
		bit eof_last;
		repeat ($urandom_range(0, 2))
			file_text_q.push_back(any_byte_but(CH_GT, CH_GT));
		repeat ($urandom_range(1, 4)) begin
			kind = $urandom_range(0, 99);
			// below 8 the header line is left empty
			if (kind >= 8) begin
				add_text(">chr");
				if (kind < 50) begin
					add_digits();
					if ($urandom_range(0, 3) == 0)
						file_text_q.push_back(any_byte_but(CH_LF, CH_LF));
				end else if (kind < 62)
					file_text_q.push_back(CH_X);
				else if (kind < 70) begin
					file_text_q.push_back(CH_X);
					file_text_q.push_back($urandom_range(0, 1) ? 8'h0D : any_byte_but(CH_LF, CH_LF));
				end else if (kind < 80) begin
					if ($urandom_range(0, 1)) begin
						add_digits();
						add_text("_alt");
					end else begin
						file_text_q.push_back(CH_US);
						add_digits();
					end
				end else if (kind < 90) begin
					case ($urandom_range(0, 2))
						0: add_text(" ");
						1: add_text("+");
						default: add_text("-");
					endcase
					add_digits();
				end else begin
					file_text_q[file_text_q.size() - 1 - $urandom_range(0, 3)] =
						any_byte_but(CH_LF, CH_LF);
					add_digits();
				end
			end
			file_text_q.push_back(CH_LF);
			add_sequence_line();
		end
		eof_last = ($urandom_range(0, 9) < 7);
		// some files stop in the middle of a record
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, file_text_q.size());
			while (file_text_q.size() > cut)
				void'(file_text_q.pop_back());
			eof_last = 1'b1;
		end
		send_file_text(eof_last);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (unmasked_items_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		logic [31:0] mask;
		mask = (reg_sel == REG_MIN_RUN) ? 32'h0000_FFFF : 32'h0000_00FF;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_sel, 2'b00};
		pwdata = ($urandom() & ~mask) | (value & mask);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_sel == REG_MIN_RUN)
			min_run_cfg = value[15:0];
		else
			x_index_cfg = value[7:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(input logic [15:0] min_run, input logic [7:0] x_index);
		wait_idle();
		apb_write(REG_MIN_RUN, {16'd0, min_run});
		apb_write(REG_X_INDEX, {24'd0, x_index});
	endtask

	// a 101-base run only just clears the reset threshold; X takes the reset index
	task automatic test_reset_defaults();
		add_text(">chrX\n");
		repeat (101)
			add_text("A");
		add_text("\n");
		send_file_text(1'b0);
	endtask

	task automatic test_header_forms();
		configure(16'd0, 8'd255);
		add_text("junk>chrX\nAN\n");
		add_text(">chr0\nA\n");
		add_text(">chr999a\nN\n");
		add_text(">chr_1\nACGT\n");
		add_text(">chrX\r\nA\n");
		add_text("\nA\n");
		add_text(">chr 5\nA\n");
		add_text(">chr12\n\n");
		send_file_text(1'b0);
		// file ends before the newline, so the record is dropped
		add_text(">chr2\nAC");
		send_file_text(1'b1);
		add_text(">chr3\nA\n");
		send_file_text(1'b0);
	endtask

	// every N closes a one-base run, so the output queue fills while the receiver holds off
	task automatic test_backpressure();
		configure(16'd0, 8'd7);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = RX_HOLD_CYCLES;
		add_text(">chr7\n");
		repeat (30)
			add_text("AN");
		add_text("\n");
		send_file_text(1'b0);
		wait_idle();
	endtask

	task automatic run_random_phase(input int tx_pct, rx_pct, input logic [15:0] min_run,
		input logic [7:0] x_index, input int goal);
		int target;
		configure(min_run, x_index);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		target = bytes_sent + goal;
		while (bytes_sent < target)
			send_random_genome();
		wait_idle();
	endtask

	initial begin
		reset_scan();
		min_run_cfg = MIN_RUN_RESET;
		x_index_cfg = X_INDEX_RESET;
		tx_idle_pct = 10;
		rx_idle_pct = 87;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_header_forms();
		test_backpressure();
		run_random_phase(10, 87, 16'd5, 8'd0, 360);
		run_random_phase(87, 10, 16'hFFFF, 8'd200, 360);
		run_random_phase(0, 0, 16'd2, 8'd22, 360);

		wait_idle();
		$display("scanned %0d bytes (%0d in header or sequence lines), checked %0d results",
			bytes_sent, parsed_bytes, results_seen);
		$display("header forms, run thresholds at both extremes, truncated files, output stalls");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> fasta_unmasked_run_finder_unit.f
src/fumrf_pkg.sv
src/fasta_unmasked_run_finder_unit.sv
tb/tb_fasta_unmasked_run_finder_unit.sv
